[rtl/core/tgad_pkg.sv]
package tgad_pkg;

    // error codes carried on the result tuser
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_TYPE  = 2'd1;
    localparam logic [1:0] ERR_MAP   = 2'd2;
    localparam logic [1:0] ERR_DEPTH = 2'd3;

    localparam int unsigned RESULT_DATA_W = 72;

    // parser to pixel unit
    typedef struct packed {
        logic        start;     // clear pixel state, load pixel total
        logic        pkt_step;  // byte is a packet header
        logic        pix_step;  // byte is a pixel byte
        logic        is_rle;
        logic        depth32;
        logic [31:0] total;
    } tgad_ctl_t;

    // pixel unit to parser
    typedef struct packed {
        logic emit;
        logic done;
        logic to_packet;
    } tgad_sts_t;

    typedef struct packed {
        logic [31:0] start_index;
        logic [7:0]  run_length;
        logic [7:0]  alpha;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
    } tgad_res_t;

endpackage

[rtl/core/tgad_ctrl.sv]
module tgad_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  logic                 first,
    input  logic [7:0]           data_byte,
    input  tgad_pkg::tgad_sts_t  sts,
    output tgad_pkg::tgad_ctl_t  ctl,
    output logic                 err_valid,
    output logic [1:0]           err_code
);

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_ID     = 3'd1;
    localparam logic [2:0] PH_PACKET = 3'd2;
    localparam logic [2:0] PH_PIXEL  = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;

    localparam logic [4:0] HP_ID_LEN = 5'd0;
    localparam logic [4:0] HP_MAP    = 5'd1;
    localparam logic [4:0] HP_KIND   = 5'd2;
    localparam logic [4:0] HP_W_LO   = 5'd12;
    localparam logic [4:0] HP_W_HI   = 5'd13;
    localparam logic [4:0] HP_H_LO   = 5'd14;
    localparam logic [4:0] HP_H_HI   = 5'd15;
    localparam logic [4:0] HP_DEPTH  = 5'd16;
    localparam logic [4:0] HP_LAST   = 5'd17;

    localparam logic [7:0] KIND_RAW = 8'd2;
    localparam logic [7:0] KIND_RLE = 8'd10;
    localparam logic [7:0] DEPTH_24 = 8'd24;
    localparam logic [7:0] DEPTH_32 = 8'd32;

    logic [2:0]  phase_reg, phase_next;
    logic [4:0]  hpos_reg, hpos_next;
    logic [7:0]  id_reg, id_next;
    logic [7:0]  kind_reg, kind_next;
    logic [7:0]  map_reg, map_next;
    logic [15:0] width_reg, width_next;
    logic [15:0] height_reg, height_next;
    logic [7:0]  depth_reg, depth_next;

    logic [2:0]  ph;
    logic [4:0]  hp;
    logic [1:0]  hdr_err;
    logic        go_pix;

    always_comb begin
        if (!(kind_reg inside {KIND_RAW, KIND_RLE})) begin
            hdr_err = tgad_pkg::ERR_TYPE;
        end else if (map_reg != 8'd0) begin
            hdr_err = tgad_pkg::ERR_MAP;
        end else if (!(depth_reg inside {DEPTH_24, DEPTH_32})) begin
            hdr_err = tgad_pkg::ERR_DEPTH;
        end else begin
            hdr_err = tgad_pkg::ERR_NONE;
        end
    end

    always_comb begin
        // a first word restarts the header parse on this very byte
        ph = first ? PH_HEADER : phase_reg;
        hp = first ? 5'd0 : hpos_reg;

        phase_next  = ph;
        hpos_next   = hp;
        id_next     = id_reg;
        kind_next   = kind_reg;
        map_next    = map_reg;
        width_next  = width_reg;
        height_next = height_reg;
        depth_next  = depth_reg;
        go_pix      = 1'b0;
        err_valid   = 1'b0;
        err_code    = tgad_pkg::ERR_NONE;

        ctl          = '0;
        ctl.is_rle   = (kind_reg == KIND_RLE);
        ctl.depth32  = (depth_reg == DEPTH_32);
        ctl.total    = {16'd0, width_reg} * {16'd0, height_reg};

        case (ph)
            PH_HEADER: begin
                case (hp)
                    HP_ID_LEN: id_next = data_byte;
                    HP_MAP:    map_next = data_byte;
                    HP_KIND:   kind_next = data_byte;
                    HP_W_LO:   width_next[7:0] = data_byte;
                    HP_W_HI:   width_next[15:8] = data_byte;
                    HP_H_LO:   height_next[7:0] = data_byte;
                    HP_H_HI:   height_next[15:8] = data_byte;
                    HP_DEPTH:  depth_next = data_byte;
                    default: ;
                endcase
                if (hp == HP_LAST) begin
                    hpos_next = 5'd0;
                    if (hdr_err != tgad_pkg::ERR_NONE) begin
                        phase_next = PH_DONE;
                        err_valid  = 1'b1;
                        err_code   = hdr_err;
                    end else if (id_reg != 8'd0) begin
                        phase_next = PH_ID;
                    end else begin
                        go_pix = 1'b1;
                    end
                end else begin
                    hpos_next = hp + 5'd1;
                end
            end
            PH_ID: begin
                id_next = id_reg - 8'd1;
                if (id_reg == 8'd1) begin
                    go_pix = 1'b1;
                end
            end
            PH_PACKET: begin
                ctl.pkt_step = 1'b1;
                phase_next   = PH_PIXEL;
            end
            PH_PIXEL: begin
                ctl.pix_step = 1'b1;
                if (sts.emit && sts.done) begin
                    phase_next = PH_DONE;
                end else if (sts.emit && sts.to_packet) begin
                    phase_next = PH_PACKET;
                end
            end
            default: ;
        endcase

        if (go_pix) begin
            ctl.start = 1'b1;
            if (width_reg == 16'd0 || height_reg == 16'd0) begin
                phase_next = PH_DONE;
            end else if (ctl.is_rle) begin
                phase_next = PH_PACKET;
            end else begin
                phase_next = PH_PIXEL;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            hpos_reg  <= 5'd0;
        end else if (step) begin
            phase_reg <= phase_next;
            hpos_reg  <= hpos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            id_reg     <= id_next;
            kind_reg   <= kind_next;
            map_reg    <= map_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            depth_reg  <= depth_next;
        end
    end

endmodule

[rtl/core/tgad_pix.sv]
module tgad_pix (
    input  logic                 aclk,
    input  logic                 step,
    input  logic [7:0]           data_byte,
    input  tgad_pkg::tgad_ctl_t  ctl,
    output tgad_pkg::tgad_sts_t  sts,
    output tgad_pkg::tgad_res_t  res
);

    logic [1:0]  byte_reg, byte_next;
    logic [23:0] bytes_reg, bytes_next;
    logic [7:0]  prem_reg, prem_next;
    logic        run_reg, run_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] remain_reg, remain_next;

    logic        last_byte;
    logic [7:0]  len;
    logic [7:0]  len_c;

    always_comb begin
        byte_next   = byte_reg;
        bytes_next  = bytes_reg;
        prem_next   = prem_reg;
        run_next    = run_reg;
        pos_next    = pos_reg;
        remain_next = remain_reg;
        sts         = '0;

        last_byte = ctl.depth32 ? (byte_reg == 2'd3) : (byte_reg == 2'd2);

        len = 8'd1;
        if (ctl.is_rle && run_reg) begin
            len = prem_reg;
        end
        // clip to the pixels left in the image
        len_c = len;
        if (remain_reg[31:8] == 24'd0 && remain_reg[7:0] < len) begin
            len_c = remain_reg[7:0];
        end

        res.red         = bytes_reg[7:0];
        res.green       = bytes_reg[15:8];
        res.blue        = ctl.depth32 ? bytes_reg[23:16] : data_byte;
        res.alpha       = ctl.depth32 ? data_byte : 8'd0;
        res.run_length  = len_c;
        res.start_index = pos_reg;

        if (ctl.start) begin
            byte_next   = 2'd0;
            bytes_next  = 24'd0;
            prem_next   = 8'd0;
            run_next    = 1'b0;
            pos_next    = 32'd0;
            remain_next = ctl.total;
        end else if (ctl.pkt_step) begin
            run_next  = data_byte[7];
            prem_next = {1'b0, data_byte[6:0]} + 8'd1;
        end else if (ctl.pix_step) begin
            if (!last_byte) begin
                case (byte_reg)
                    2'd0:    bytes_next[7:0]   = data_byte;
                    2'd1:    bytes_next[15:8]  = data_byte;
                    2'd2:    bytes_next[23:16] = data_byte;
                    default: ;
                endcase
                byte_next = byte_reg + 2'd1;
            end else begin
                byte_next  = 2'd0;
                bytes_next = 24'd0;
                if (ctl.is_rle) begin
                    if (run_reg) begin
                        prem_next = 8'd0;
                    end else if (prem_reg != 8'd0) begin
                        prem_next = prem_reg - 8'd1;
                    end
                end
                pos_next      = pos_reg + {24'd0, len_c};
                remain_next   = remain_reg - {24'd0, len_c};
                sts.emit      = 1'b1;
                sts.done      = (remain_reg == {24'd0, len_c});
                sts.to_packet = ctl.is_rle && (prem_next == 8'd0);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            byte_reg   <= byte_next;
            bytes_reg  <= bytes_next;
            prem_reg   <= prem_next;
            run_reg    <= run_next;
            pos_reg    <= pos_next;
            remain_reg <= remain_next;
        end
    end

endmodule

[rtl/core/tga_rle_pixel_decoder_top.sv]
// TGA true-colour decoder. Feed the file one byte per word on the s_ side, with
// s_tuser set on byte 0 of each file. Types 2 (raw) and 10 (RLE), no colour
// map, 24 or 32 bits per pixel are decoded; anything else yields a single word
// with run_length 0, m_tlast set and the error code on m_tuser. Each pixel or
// RLE run comes out as one word: colour in file byte order, run length
// (clipped to the image) and the linear index of its first pixel; m_tlast
// marks the run that completes the image. Bytes after the image, or after an
// error, are dropped until the next s_tuser. One byte is taken every cycle
// while the output is not stalled; the last byte of a result passes through
// the input register, then the output register, before the result is
// presented on m_tvalid.
module tga_rle_pixel_decoder_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] first
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [tgad_pkg::RESULT_DATA_W-1:0] m_tdata,
    // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha,
    // [39:32] run_length, [71:40] start_index
    output logic        m_tlast,
    output logic [1:0]  m_tuser    // [1:0] error_code
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_data_reg;
    logic       in_first_reg;

    logic                                   out_valid_reg, out_valid_next;
    logic [tgad_pkg::RESULT_DATA_W-1:0]     out_data_reg;
    logic                                   out_last_reg;
    logic [1:0]                             out_err_reg;

    logic                 out_free;
    logic                 advance;
    logic                 emit;
    tgad_pkg::tgad_ctl_t  ctl;
    tgad_pkg::tgad_sts_t  sts;
    tgad_pkg::tgad_res_t  res;
    logic                 err_valid;
    logic [1:0]           err_code;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign emit     = err_valid || sts.emit;

    tgad_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .first     (in_first_reg),
        .data_byte (in_data_reg),
        .sts       (sts),
        .ctl       (ctl),
        .err_valid (err_valid),
        .err_code  (err_code)
    );

    tgad_pix u_pix (
        .aclk      (aclk),
        .step      (advance),
        .data_byte (in_data_reg),
        .ctl       (ctl),
        .sts       (sts),
        .res       (res)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance && emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg  <= s_tdata;
            in_first_reg <= s_tuser[0];
        end
        if (advance && emit) begin
            if (err_valid) begin
                out_data_reg <= '0;
                out_last_reg <= 1'b1;
                out_err_reg  <= err_code;
            end else begin
                out_data_reg <= res;
                out_last_reg <= sts.done;
                out_err_reg  <= tgad_pkg::ERR_NONE;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_err_reg;

    // header errors carry no pixels and always close the file
    a_err_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != tgad_pkg::ERR_NONE |-> m_tlast && m_tdata[39:32] == 8'd0)
        else $error("error word with pixels or without tlast");

    // a pixel word always covers at least one pixel
    a_run_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == tgad_pkg::ERR_NONE |-> m_tdata[39:32] != 8'd0)
        else $error("pixel word with zero run length");

    // a stalled output must hold the pending byte in the input register
    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_free |=> in_valid_reg && $stable(in_data_reg))
        else $error("input byte lost during output stall");

    // pixel unit only reports a result while the parser is in a pixel step
    a_emit_gated: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.emit |-> ctl.pix_step && !err_valid)
        else $error("pixel result outside pixel phase");

endmodule

[verif/tga_rle_pixel_decoder_top_tb.sv]
`timescale 1ns / 1ps

module tga_rle_pixel_decoder_top_tb;

    localparam logic [7:0] KIND_CMAP      = 8'd1;
    localparam logic [7:0] KIND_RAW       = 8'd2;
    localparam logic [7:0] KIND_RLE       = 8'd10;
    localparam logic [7:0] DEPTH_16       = 8'd16;
    localparam logic [7:0] DEPTH_24       = 8'd24;
    localparam logic [7:0] DEPTH_32       = 8'd32;
    localparam logic [7:0] PKT_RUN_BIT    = 8'h80;
    localparam logic [7:0] PKT_COUNT_MASK = 8'h7F;
    localparam logic [4:0] HDR_LAST       = 5'd17;

    localparam int BYTE_TARGET  = 1850;
    localparam int HOLD_AT_WORD = 80;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 3000;

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_ID     = 3'd1;
    localparam logic [2:0] PH_PACKET = 3'd2;
    localparam logic [2:0] PH_PIXEL  = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;

    typedef struct packed {
        tgad_pkg::tgad_res_t px;
        logic                last;
        logic [1:0]          err;
    } run_word_t;

    typedef struct {
        logic [7:0] data;
        logic       first;
        int         gap;
        bit         drain;
    } file_byte_t;

    logic                               aclk = 1'b0;
    logic                               aresetn = 1'b0;
    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    logic [7:0]                         s_tdata = '0;   // [7:0] data_byte
    logic [0:0]                         s_tuser = '0;   // [0] first
    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    logic [tgad_pkg::RESULT_DATA_W-1:0] m_tdata;
    // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha,
    // [39:32] run_length, [71:40] start_index
    logic                               m_tlast;
    logic [1:0]                         m_tuser;        // [1:0] error_code

    tga_rle_pixel_decoder_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // decoder state as the block should hold it
    logic [2:0]   dec_phase;
    logic [4:0]   hdr_pos;
    logic [7:0]   id_left;
    logic [7:0]   img_kind;
    logic [7:0]   map_kind;
    logic [15:0]  img_w;
    logic [15:0]  img_h;
    logic [7:0]   depth;
    logic [31:0]  px_total;
    logic [31:0]  px_pos;
    logic [7:0]   pkt_left;
    logic         pkt_run;
    logic [1:0]   px_byte;
    logic [23:0]  px_acc;

    file_byte_t          pending_bytes[$];
    run_word_t           expected_runs[$];
    file_byte_t          tx_item;
    run_word_t           exp_run;
    tgad_pkg::tgad_res_t act_px;
    bit                  run_due;

    int  gap_left = 0;
    logic draining = 1'b0;
    logic drained = 1'b1;
    int  in_count = 0;
    int  total_bytes = 0;
    int  n_useful = 0;
    int  n_headers = 0;
    int  n_rejected = 0;
    int  n_clipped = 0;
    int  words_out = 0;
    int  fail_count = 0;
    int  rx_wait = 0;
    int  rx_draw = 0;
    int  hold_left = 0;
    int  rx_words = 0;
    bit  rx_burst = 1'b0;
    int  idle_cycles = 0;
    bit  burst = 1'b0;

    task automatic clear_decoder();
        dec_phase = PH_HEADER;
        hdr_pos   = '0;
        id_left   = '0;
        img_kind  = '0;
        map_kind  = '0;
        img_w     = '0;
        img_h     = '0;
        depth     = '0;
        px_total  = '0;
        px_pos    = '0;
        pkt_left  = '0;
        pkt_run   = 1'b0;
        px_byte   = '0;
        px_acc    = '0;
    endtask

    task automatic start_pixels();
        px_byte  = '0;
        px_acc   = '0;
        pkt_left = '0;
        pkt_run  = 1'b0;
        if (px_total == 0)
            dec_phase = PH_DONE;
        else
            dec_phase = (img_kind == KIND_RLE) ? PH_PACKET : PH_PIXEL;
    endtask

    task automatic decode_tga_byte(input logic [7:0] d, input logic f,
                                   output bit got, output run_word_t w);
        logic [1:0]  err;
        logic [31:0] run_len;
        logic [31:0] left;
        int          nb;
        got = 1'b0;
        w   = '0;
        if (f)
            clear_decoder();
        case (dec_phase)
            PH_HEADER: begin
                case (hdr_pos)
                    5'd0:    id_left = d;
                    5'd1:    map_kind = d;
                    5'd2:    img_kind = d;
                    5'd12:   img_w[7:0] = d;
                    5'd13:   img_w[15:8] = d;
                    5'd14:   img_h[7:0] = d;
                    5'd15:   img_h[15:8] = d;
                    5'd16:   depth = d;
                    default: ;
                endcase
                if (hdr_pos < HDR_LAST) begin
                    hdr_pos = hdr_pos + 5'd1;
                end else begin
                    hdr_pos = '0;
                    // order matters: type, then colour map, then depth
                    if (img_kind != KIND_RAW && img_kind != KIND_RLE)
                        err = tgad_pkg::ERR_TYPE;
                    else if (map_kind != 0)
                        err = tgad_pkg::ERR_MAP;
                    else if (depth != DEPTH_32 && depth != DEPTH_24)
                        err = tgad_pkg::ERR_DEPTH;
                    else
                        err = tgad_pkg::ERR_NONE;
                    if (err != tgad_pkg::ERR_NONE) begin
                        dec_phase = PH_DONE;
                        got       = 1'b1;
                        w.last    = 1'b1;
                        w.err     = err;
                        n_rejected++;
                    end else begin
                        px_total = {16'd0, img_w} * {16'd0, img_h};
                        px_pos   = '0;
                        if (id_left != 0)
                            dec_phase = PH_ID;
                        else
                            start_pixels();
                    end
                end
            end
            PH_ID: begin
                id_left = id_left - 8'd1;
                if (id_left == 0)
                    start_pixels();
            end
            PH_PACKET: begin
                pkt_run   = (d & PKT_RUN_BIT) != 0;
                pkt_left  = (d & PKT_COUNT_MASK) + 8'd1;
                dec_phase = PH_PIXEL;
            end
            PH_PIXEL: begin
                nb = (depth == DEPTH_32) ? 4 : 3;
                if (px_byte + 1 < nb) begin
                    px_acc  = px_acc | ({16'd0, d} << (8 * px_byte));
                    px_byte = px_byte + 2'd1;
                end else begin
                    w.px.red   = px_acc[7:0];
                    w.px.green = px_acc[15:8];
                    if (nb == 4) begin
                        w.px.blue  = px_acc[23:16];
                        w.px.alpha = d;
                    end else begin
                        w.px.blue  = d;
                        w.px.alpha = 8'd0;
                    end
                    px_byte = '0;
                    px_acc  = '0;
                    run_len = 32'd1;
                    if (img_kind == KIND_RLE) begin
                        if (pkt_run) begin
                            run_len  = {24'd0, pkt_left};
                            pkt_left = '0;
                        end else if (pkt_left != 0) begin
                            pkt_left = pkt_left - 8'd1;
                        end
                    end
                    left = px_total - px_pos;
                    if (run_len > left) begin
                        run_len = left;
                        n_clipped++;
                    end
                    w.px.run_length  = run_len[7:0];
                    w.px.start_index = px_pos;
                    px_pos = px_pos + run_len;
                    w.last = (px_pos == px_total);
                    got    = 1'b1;
                    if (px_pos == px_total)
                        dec_phase = PH_DONE;
                    else if (img_kind == KIND_RLE && pkt_left == 0)
                        dec_phase = PH_PACKET;
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] seen);
        if (seen !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, seen);
            fail_count++;
        end
    endtask

    // ---------------------------------------------------------------- stimulus

    function automatic logic [7:0] rand_px_byte();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
            return 8'h00;
        else if (pick == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic bit file_ok(logic [7:0] kind, logic [7:0] map, logic [7:0] dep);
        return (kind == KIND_RAW || kind == KIND_RLE) && map == 0 &&
               (dep == DEPTH_24 || dep == DEPTH_32);
    endfunction

    task automatic push_byte(input logic [7:0] d, input logic f, input bit ignored);
        file_byte_t b;
        b.data  = d;
        b.first = f;
        b.gap   = burst ? 0 : $urandom_range(0, 14);
        b.drain = 1'b0;
        pending_bytes.push_back(b);
        total_bytes++;
        if (!ignored)
            n_useful++;
    endtask

    task automatic push_junk(input int n);
        for (int i = 0; i < n; i++)
            push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    task automatic push_pixel(input int nb);
        for (int i = 0; i < nb; i++)
            push_byte(rand_px_byte(), 1'b0, 1'b0);
    endtask

    task automatic push_header(input logic f, input logic [7:0] id_len, input logic [7:0] map,
                               input logic [7:0] kind, input logic [15:0] w,
                               input logic [15:0] h, input logic [7:0] dep);
        push_byte(id_len, f, 1'b0);
        push_byte(map, 1'b0, 1'b0);
        push_byte(kind, 1'b0, 1'b0);
        // map spec and origin are don't-care to the decoder
        for (int i = 3; i < 12; i++)
            push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        push_byte(w[7:0], 1'b0, 1'b0);
        push_byte(w[15:8], 1'b0, 1'b0);
        push_byte(h[7:0], 1'b0, 1'b0);
        push_byte(h[15:8], 1'b0, 1'b0);
        push_byte(dep, 1'b0, 1'b0);
        push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        for (int i = 0; i < id_len; i++)
            push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        n_headers++;
    endtask

    task automatic push_body(input logic [7:0] kind, input logic [7:0] dep, input int total);
        int nb;
        int left;
        int cnt;
        int sent;
        nb   = (dep == DEPTH_32) ? 4 : 3;
        left = total;
        while (left > 0) begin
            if (kind != KIND_RLE) begin
                push_pixel(nb);
                left--;
            end else begin
                cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 128)
                                                  : $urandom_range(1, 4);
                if ($urandom_range(0, 1) == 1) begin
                    push_byte(PKT_RUN_BIT | 8'(cnt - 1), 1'b0, 1'b0);
                    push_pixel(nb);
                    left = (cnt > left) ? 0 : left - cnt;
                end else begin
                    // a literal packet simply stops once the image is full
                    push_byte(8'(cnt - 1), 1'b0, 1'b0);
                    sent = (cnt > left) ? left : cnt;
                    for (int i = 0; i < sent; i++)
                        push_pixel(nb);
                    left -= sent;
                end
            end
        end
    endtask

    task automatic push_file(input logic f, input logic [7:0] kind, input logic [7:0] map,
                             input logic [7:0] dep, input logic [15:0] w,
                             input logic [15:0] h, input logic [7:0] id_len);
        push_header(f, id_len, map, kind, w, h, dep);
        if (file_ok(kind, map, dep))
            push_body(kind, dep, int'(w) * int'(h));
    endtask

    task automatic push_pause();
        file_byte_t b;
        b.data  = '0;
        b.first = 1'b0;
        b.gap   = 0;
        b.drain = 1'b1;
        pending_bytes.push_back(b);
    endtask

    task automatic build_directed();
        // straight out of reset with no first flag on byte 0
        push_file(1'b0, KIND_RAW, 8'd0, DEPTH_24, 16'd2, 16'd1, 8'd0);
        // run of 128 over a 3-pixel image, then bytes past the end
        push_header(1'b1, 8'd0, 8'd0, KIND_RLE, 16'd3, 16'd1, DEPTH_32);
        push_byte(8'hFF, 1'b0, 1'b0);
        push_pixel(4);
        push_junk(3);
        // longest ID field, then an all-ones pixel
        push_header(1'b1, 8'd255, 8'd0, KIND_RAW, 16'd1, 16'd1, DEPTH_24);
        for (int i = 0; i < 3; i++)
            push_byte(8'hFF, 1'b0, 1'b0);
        // rejected headers, one per error code
        push_header(1'b1, 8'd0, 8'd1, KIND_CMAP, 16'd2, 16'd2, DEPTH_24);
        push_junk(2);
        push_header(1'b1, 8'd0, 8'd1, KIND_RLE, 16'd2, 16'd2, DEPTH_16);
        push_header(1'b1, 8'd0, 8'd0, KIND_RAW, 16'd2, 16'd2, 8'd8);
        // empty image
        push_header(1'b1, 8'd0, 8'd0, KIND_RLE, 16'd0, 16'd5, DEPTH_32);
        push_junk(2);
        // literal packet of 128 into a 2-pixel image
        push_header(1'b1, 8'd0, 8'd0, KIND_RLE, 16'd2, 16'd1, DEPTH_24);
        push_byte(PKT_COUNT_MASK, 1'b0, 1'b0);
        push_pixel(3);
        push_pixel(3);
        push_junk(2);
        // largest image, cut short by the next file
        push_header(1'b1, 8'd0, 8'd0, KIND_RAW, 16'hFFFF, 16'hFFFF, DEPTH_32);
        push_pixel(12);
        // header abandoned half way
        push_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0);
        push_pixel(8);
        push_file(1'b1, KIND_RLE, 8'd0, DEPTH_24, 16'd3, 16'd2, 8'd2);
    endtask

    task automatic build_random();
        int          sel;
        int          n;
        bit          paused;
        logic [7:0]  kind;
        logic [7:0]  map;
        logic [7:0]  dep;
        logic [15:0] w;
        logic [15:0] h;
        logic [7:0]  id_len;
        paused = 1'b0;
        while (n_useful < BYTE_TARGET) begin
            burst = ($urandom_range(0, 3) == 0);
            if (!paused && n_useful > BYTE_TARGET / 2) begin
                push_pause();
                paused = 1'b1;
            end
            sel    = $urandom_range(0, 99);
            kind   = $urandom_range(0, 1) ? KIND_RLE : KIND_RAW;
            dep    = $urandom_range(0, 1) ? DEPTH_32 : DEPTH_24;
            map    = 8'd0;
            id_len = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 3)) : 8'd0;
            if (sel < 60) begin
                w = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 3));
                h = 16'($urandom_range(1, 3));
                push_file(1'b1, kind, 8'd0, dep, w, h, id_len);
                if ($urandom_range(0, 2) == 0)
                    push_junk($urandom_range(1, 3));
            end else if (sel < 72) begin
                // mostly broken headers, the odd good one gets through
                case ($urandom_range(0, 2))
                    0:       kind = 8'($urandom_range(0, 255));
                    1:       map = 8'($urandom_range(1, 255));
                    default: dep = 8'($urandom_range(0, 255));
                endcase
                if (sel < 66)
                    map = 8'd0;
                push_file(1'b1, kind, map, dep, 16'($urandom_range(0, 2)),
                          16'($urandom_range(0, 2)), id_len);
                push_junk($urandom_range(0, 2));
            end else if (sel < 84) begin
                push_header(1'b1, id_len, 8'd0, kind, 16'($urandom_range(1, 16'hFFFF)),
                            16'($urandom_range(1, 16'hFFFF)), dep);
                push_pixel($urandom_range(0, 20));
            end else if (sel < 94) begin
                n = $urandom_range(1, 30);
                push_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0);
                for (int i = 1; i < n; i++)
                    push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0, 1'b0);
            end else begin
                push_junk($urandom_range(2, 6));
            end
        end
    endtask

    // ---------------------------------------------------------------- sender

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            gap_left <= 0;
            draining <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (draining) begin
                s_tvalid <= 1'b0;
                if (drained)
                    draining <= 1'b0;
            end else if (gap_left != 0) begin
                s_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_bytes.size() != 0) begin
                tx_item = pending_bytes.pop_front();
                if (tx_item.drain) begin
                    s_tvalid <= 1'b0;
                    draining <= 1'b1;
                end else begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= tx_item.data;
                    s_tuser  <= tx_item.first;
                    gap_left <= tx_item.gap;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- receiver

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            rx_wait   <= 0;
            hold_left <= 0;
            rx_words  <= 0;
            rx_burst  <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (m_tvalid && m_tready) begin
            rx_words <= rx_words + 1;
            if (rx_words % 32 == 31)
                rx_burst <= ($urandom_range(0, 3) == 0);
            if (rx_words == HOLD_AT_WORD) begin
                // long back-pressure so the decoder fills and stalls its input
                m_tready  <= 1'b0;
                hold_left <= HOLD_CYCLES;
            end else begin
                rx_draw  = rx_burst ? 0 : $urandom_range(0, 14);
                m_tready <= (rx_draw == 0);
                rx_wait  <= rx_draw;
            end
        end else if (rx_wait != 0) begin
            rx_wait  <= rx_wait - 1;
            m_tready <= (rx_wait == 1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- checker

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_decoder();
            drained  <= 1'b1;
            in_count <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                decode_tga_byte(s_tdata, s_tuser[0], run_due, exp_run);
                if (run_due)
                    expected_runs.push_back(exp_run);
                in_count <= in_count + 1;
            end
            if (m_tvalid && m_tready) begin
                act_px = m_tdata;
                if (expected_runs.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual %0h last %0b err %0d",
                             $time, m_tdata, m_tlast, m_tuser);
                    fail_count++;
                end else begin
                    exp_run = expected_runs.pop_front();
                    check_field("red", exp_run.px.red, act_px.red);
                    check_field("green", exp_run.px.green, act_px.green);
                    check_field("blue", exp_run.px.blue, act_px.blue);
                    check_field("alpha", exp_run.px.alpha, act_px.alpha);
                    check_field("run_length", exp_run.px.run_length, act_px.run_length);
                    check_field("start_index", exp_run.px.start_index, act_px.start_index);
                    check_field("last", exp_run.last, m_tlast);
                    check_field("error_code", exp_run.err, m_tuser);
                end
                words_out++;
            end
            drained <= (expected_runs.size() == 0);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        build_directed();
        build_random();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        while (in_count != total_bytes || !drained)
            @(posedge aclk);
        // catch any stray word after the last expected one
        repeat (8) @(posedge aclk);
        $display("Fed %0d file bytes over %0d headers (%0d rejected), raw and RLE, 24/32 bit.",
                 total_bytes, n_headers, n_rejected);
        $display("Checked %0d result words, %0d of them runs clipped at the image end.",
                 words_out, n_clipped);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
